// ----- hdl/sha1_message_hasher_assert.svh -----
// Assertion macros for the SHA-1 message hasher.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SMH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 check failed");

// Next-cycle implication, disabled while reset is low.
`define SMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 check failed");

`endif

// ----- hdl/sha1mh_pkg.sv -----
// Package for the SHA-1 message hasher: word type and the hash constants.
// No dependencies.
`default_nettype none

package sha1mh_pkg;

    typedef logic [31:0] t_word;

    localparam t_word H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    // Round constant by round number 0..79
    function automatic t_word round_k(input logic [6:0] t);
        t_word k;
        if (t < 7'd20) begin
            k = K_ROUND[0];
        end else if (t < 7'd40) begin
            k = K_ROUND[1];
        end else if (t < 7'd60) begin
            k = K_ROUND[2];
        end else begin
            k = K_ROUND[3];
        end
        return k;
    endfunction

    // Round function by round number
    function automatic t_word round_f(input logic [6:0] t, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t >= 7'd40 && t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sha1mh_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module sha1mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

// ----- hdl/sha1_message_hasher.sv -----
// SHA-1 message hasher: one beat per byte, a byte per cycle when no block completes.
// A block runs CA (setup), then CB and CR for each of the 80 rounds, then CADD (add).
// One 16-word buffer RAM with two read ports feeds the message schedule. End of
// message: pad bytes one per cycle unless a block compresses, length words, final
// compression, five digest beats (one on error). Sync active-low reset loads H_INIT.
`default_nettype none

module sha1_message_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [3:0]  i_valid_bits,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic [1:0]       o_status,
    output logic             o_last_word
);

`include "sha1_message_hasher_assert.svh"

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PADB = 4'd1;
    localparam logic [3:0] ST_PAD  = 4'd2;
    localparam logic [3:0] ST_LEN  = 4'd3;
    localparam logic [3:0] ST_CA   = 4'd4;
    localparam logic [3:0] ST_CB   = 4'd5;
    localparam logic [3:0] ST_CR   = 4'd6;
    localparam logic [3:0] ST_CADD = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_ERR  = 4'd9;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PARTIAL  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    logic [3:0]  r_state;
    logic [3:0]  r_ret;
    logic [5:0]  r_pos;
    logic [31:0] r_word;
    logic [63:0] r_len;
    logic [1:0]  r_err;
    logic [7:0]  r_pad;
    logic [6:0]  r_t;
    logic [2:0]  r_k;
    logic [31:0] r_xa;
    sha1mh_pkg::t_word r_h [5];
    sha1mh_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    logic        r_ovalid;

    // Input beat decode
    logic        acc;
    logic [3:0]  vb;
    logic        full, part, ok, carry;
    logic [64:0] sum;
    logic [1:0]  err_end;

    assign acc   = i_valid && !o_stall;
    assign vb    = i_valid_bits[3] ? 4'd8 : i_valid_bits;
    assign full  = vb[3];
    assign part  = !full && (vb != 4'd0);
    assign ok    = (r_err == ERR_NONE);
    assign sum   = {1'b0, r_len} + {61'd0, vb};
    assign carry = sum[64];

    always_comb begin
        err_end = r_err;
        if (ok && (full || part) && carry) begin
            err_end = ERR_OVERFLOW;
        end
    end

    // Byte insertion into the block buffer
    logic       put_en;
    logic [7:0] put_val;
    logic       wrap;
    logic [31:0] put_word;

    always_comb begin
        put_en  = 1'b0;
        put_val = 8'd0;
        unique case (r_state)
            ST_IDLE: begin
                put_en  = acc && full && ok && !carry;
                put_val = i_byte_value;
            end
            ST_PADB: begin
                put_en  = 1'b1;
                put_val = r_pad;
            end
            ST_PAD: begin
                put_en  = (r_pos != 6'd56);
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    assign wrap     = put_en && (r_pos == 6'd63);
    assign put_word = {r_word[23:0], put_val};

    // Schedule and round datapath
    logic [3:0]  t4, idx;
    logic [3:0]  raddr0, raddr1;
    logic [31:0] rd0, rd1;
    logic [31:0] wx, w, tmp;
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;

    assign t4  = r_t[3:0];
    assign idx = (r_state == ST_CR) ? t4 + 4'd1 : t4;

    // Reads t-3, t-8 first, then t-14 and t-16 (or word t itself in the first 16)
    always_comb begin
        if (r_state == ST_CB) begin
            raddr0 = t4 + 4'd2;
            raddr1 = t4;
        end else begin
            raddr0 = idx + 4'd13;
            raddr1 = idx + 4'd8;
        end
    end

    assign wx  = r_xa ^ rd0 ^ rd1;
    assign w   = (r_t < 7'd16) ? rd1 : {wx[30:0], wx[31]};
    assign tmp = {r_a[26:0], r_a[31:27]} + sha1mh_pkg::round_f(r_t, r_b, r_c, r_d)
               + r_e + w + sha1mh_pkg::round_k(r_t);

    always_comb begin
        we    = 1'b0;
        waddr = r_pos[5:2];
        wdata = put_word;
        if (r_state == ST_CR) begin
            we    = 1'b1;
            waddr = t4;
            wdata = w;
        end else if (r_state == ST_LEN) begin
            we    = 1'b1;
            wdata = r_pos[2] ? r_len[31:0] : r_len[63:32];
        end else if (put_en && (r_pos[1:0] == 2'd3)) begin
            we = 1'b1;
        end
    end

    sha1mh_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr0(raddr0),
        .i_raddr1(raddr1),
        .o_rdata0(rd0),
        .o_rdata1(rd1)
    );

    logic slot_free;
    logic out_load;
    assign slot_free = !r_ovalid || !i_stall;
    assign out_load  = slot_free && ((r_state == ST_OUT) || (r_state == ST_ERR));
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_ovalid;

    // Sequencer and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_pos    <= 6'd0;
            r_len    <= 64'd0;
            r_err    <= ERR_NONE;
            r_t      <= 7'd0;
            r_k      <= 3'd0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1mh_pkg::H_INIT[i];
            end
        end else begin
            // Output beat register: load a new beat or drop the one taken
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            if (put_en) begin
                r_word <= put_word;
                r_pos  <= r_pos + 6'd1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (full && ok && !carry) begin
                            r_len <= sum[63:0];
                        end
                        if (i_end_of_message) begin
                            if (err_end != ERR_NONE) begin
                                r_err   <= err_end;
                                r_state <= ST_ERR;
                            end else begin
                                r_pad <= part ? ((i_byte_value & ~(8'hFF >> vb[2:0]))
                                                 | (8'h80 >> vb[2:0])) : 8'h80;
                                if (part) begin
                                    r_len <= sum[63:0];
                                end
                                if (!wrap) begin
                                    r_state <= ST_PADB;
                                end
                                r_ret <= ST_PADB;
                            end
                        end else begin
                            if (ok && full && carry) begin
                                r_err <= ERR_OVERFLOW;
                            end else if (ok && part) begin
                                r_err <= ERR_PARTIAL;
                            end
                            r_ret <= ST_IDLE;
                        end
                    end
                end
                ST_PADB: begin
                    if (!wrap) begin
                        r_state <= ST_PAD;
                    end
                    r_ret <= ST_PAD;
                end
                ST_PAD: begin
                    r_ret <= ST_PAD;
                    if (r_pos == 6'd56) begin
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    r_pos <= r_pos + 6'd4;
                    if (r_pos == 6'd60) begin
                        r_ret   <= ST_OUT;
                        r_state <= ST_CA;
                        r_t     <= 7'd0;
                        r_a     <= r_h[0];
                        r_b     <= r_h[1];
                        r_c     <= r_h[2];
                        r_d     <= r_h[3];
                        r_e     <= r_h[4];
                    end
                end
                ST_CA: begin
                    r_state <= ST_CB;
                end
                ST_CB: begin
                    r_xa    <= rd0 ^ rd1;
                    r_state <= ST_CR;
                end
                ST_CR: begin
                    r_a <= tmp;
                    r_b <= r_a;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_d <= r_c;
                    r_e <= r_d;
                    if (r_t == 7'd79) begin
                        r_state <= ST_CADD;
                    end else begin
                        r_t     <= r_t + 7'd1;
                        r_state <= ST_CB;
                    end
                end
                ST_CADD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_state <= r_ret;
                end
                ST_OUT: begin
                    if (slot_free) begin
                        o_digest_word <= r_h[r_k];
                        o_word_index  <= r_k;
                        o_status      <= ERR_NONE;
                        o_last_word   <= (r_k == 3'd4);
                        if (r_k == 3'd4) begin
                            r_k     <= 3'd0;
                            r_state <= ST_IDLE;
                            r_pos   <= 6'd0;
                            r_len   <= 64'd0;
                            r_err   <= ERR_NONE;
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= sha1mh_pkg::H_INIT[i];
                            end
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                ST_ERR: begin
                    if (slot_free) begin
                        o_digest_word <= 32'd0;
                        o_word_index  <= 3'd0;
                        o_status      <= r_err;
                        o_last_word   <= 1'b1;
                        r_state       <= ST_IDLE;
                        r_pos         <= 6'd0;
                        r_len         <= 64'd0;
                        r_err         <= ERR_NONE;
                        for (int i = 0; i < 5; i++) begin
                            r_h[i] <= sha1mh_pkg::H_INIT[i];
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // A completed block diverts to compression, then resumes
            if (wrap) begin
                r_state <= ST_CA;
                r_t     <= 7'd0;
                r_a     <= r_h[0];
                r_b     <= r_h[1];
                r_c     <= r_h[2];
                r_d     <= r_h[3];
                r_e     <= r_h[4];
            end
        end
    end

    // Checks
    `SMH_ASSERT_NOW(a_round_range, i_clk, i_rst_n,
        (r_state == ST_CA || r_state == ST_CB || r_state == ST_CR), (r_t <= 7'd79))
    `SMH_ASSERT_NOW(a_word_range, i_clk, i_rst_n, (r_state == ST_OUT), (r_k <= 3'd4))
    `SMH_ASSERT_NOW(a_last_ok, i_clk, i_rst_n, (o_valid && o_last_word),
        (o_word_index == 3'd4 || o_status != ERR_NONE))
    `SMH_ASSERT_NEXT(a_eom_busy, i_clk, i_rst_n, (acc && i_end_of_message),
        (r_state != ST_IDLE))

endmodule

`default_nettype wire

// ----- tb/sha1_message_hasher_test.sv -----
// Self-checking bench for the SHA-1 message hasher: byte beats in, digest beats out.
// Depends on hdl/sha1_message_hasher.sv and the sha1mh_pkg package.
`default_nettype none

module sha1_message_hasher_test;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic [1:0]  status;
        logic        last_word;
    } t_digest_beat;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PARTIAL  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam int         CYCLE_LIMIT     = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_byte_value;
    logic [3:0]  i_valid_bits;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic [1:0]  o_status;
    logic        o_last_word;

    sha1_message_hasher dut (.*);

    // Predictor state
    sha1mh_pkg::t_word pred_block [16];
    sha1mh_pkg::t_word chain [5];
    logic [63:0] msg_bits;
    int unsigned msg_pos;
    logic [1:0]  msg_err;

    t_digest_beat expected_digests [$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  rx_idle_free;
    bit  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic sha1mh_pkg::t_word rotl(sha1mh_pkg::t_word x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_pred_block();
        sha1mh_pkg::t_word w [80];
        sha1mh_pkg::t_word a, b, c, d, e, f, k, tmp;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int t = 0; t < 16; t++) w[t] = pred_block[t];
        for (int t = 16; t < 80; t++) w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            tmp = rotl(a, 5) + f + e + w[t] + k;
            e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic append_byte(logic [7:0] v);
        int sh;
        sh = 24 - 8 * (msg_pos % 4);
        pred_block[msg_pos / 4] = (pred_block[msg_pos / 4] & ~(32'hFF << sh))
                                | (sha1mh_pkg::t_word'(v) << sh);
        msg_pos++;
        if (msg_pos == 64) begin
            compress_pred_block();
            msg_pos = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 16; i++) pred_block[i] = '0;
        for (int i = 0; i < 5; i++) chain[i] = sha1mh_pkg::H_INIT[i];
        msg_bits = '0;
        msg_pos  = 0;
        msg_err  = STATUS_OK;
    endtask

    // Update the predictor with one accepted beat and queue any digest beats
    task automatic predict_digest(logic [7:0] bv, logic [3:0] vb_in, logic eom);
        int unsigned vb;
        logic [7:0]  pad;
        logic [64:0] sum;
        t_digest_beat r;
        vb  = (vb_in > 8) ? 8 : vb_in;
        pad = 8'h80;
        if (vb == 8 && msg_err == STATUS_OK) begin
            sum = {1'b0, msg_bits} + 65'd8;
            if (sum[64]) msg_err = STATUS_OVERFLOW;
            else begin
                msg_bits = sum[63:0];
                append_byte(bv);
            end
        end else if (vb >= 1 && vb <= 7 && !eom && msg_err == STATUS_OK) begin
            msg_err = STATUS_PARTIAL;
        end
        if (!eom) return;
        if (msg_err == STATUS_OK && vb >= 1 && vb <= 7) begin
            sum = {1'b0, msg_bits} + 65'(vb);
            if (sum[64]) msg_err = STATUS_OVERFLOW;
            else begin
                msg_bits = sum[63:0];
                pad = (bv & (8'hFF << (8 - vb))) | (8'h80 >> vb);
            end
        end
        if (msg_err != STATUS_OK) begin
            r = '{digest_word: '0, word_index: '0, status: msg_err, last_word: 1'b1};
            expected_digests.push_back(r);
            restart_message();
            return;
        end
        append_byte(pad);
        if (msg_pos > 56) while (msg_pos != 0) append_byte(8'h00);
        while (msg_pos < 56) append_byte(8'h00);
        pred_block[14] = msg_bits[63:32];
        pred_block[15] = msg_bits[31:0];
        compress_pred_block();
        msg_pos = 0;
        for (int k = 0; k < 5; k++) begin
            r = '{digest_word: chain[k], word_index: 3'(k), status: STATUS_OK,
                  last_word: (k == 4)};
            expected_digests.push_back(r);
        end
        restart_message();
    endtask

    // Send one beat; random idle cycles ahead of it unless free-running.
    // Valid stays up after the beat is taken; the next beat or the drain drops it.
    task automatic send_beat(logic [7:0] bv, logic [3:0] vb, logic eom, bit gaps = 1);
        while (gaps && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_byte_value     <= bv;
        i_valid_bits     <= vb;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(bv, vb, eom);
    endtask

    task automatic send_message(int len, bit gaps = 1);
        int unsigned tail;
        for (int i = 0; i < len; i++) send_beat(8'($urandom), 4'd8, 1'b0, gaps);
        tail = $urandom_range(9);
        if (tail == 0) send_beat(8'($urandom), 4'd0, 1'b1, gaps);
        else if (tail < 5) send_beat(8'($urandom), 4'($urandom_range(7, 1)), 1'b1, gaps);
        else send_beat(8'($urandom), 4'($urandom_range(15, 8)), 1'b1, gaps);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_digests.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // Receiver side: random stall, with a free stretch and a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= rx_hold || (!rx_idle_free && $urandom_range(99) < 20);
    end

    // Digest beat checker
    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_digests.size() == 0) begin
                $error("unexpected digest beat %h", o_digest_word);
                fail_count++;
            end else begin
                exp_beat = expected_digests.pop_front();
                if (o_digest_word !== exp_beat.digest_word) begin
                    $error("digest_word expected %h actual %h", exp_beat.digest_word,
                           o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== exp_beat.word_index) begin
                    $error("word_index expected %0d actual %0d", exp_beat.word_index,
                           o_word_index);
                    fail_count++;
                end
                if (o_status !== exp_beat.status) begin
                    $error("status expected %0d actual %0d", exp_beat.status, o_status);
                    fail_count++;
                end
                if (o_last_word !== exp_beat.last_word) begin
                    $error("last_word expected %0d actual %0d", exp_beat.last_word,
                           o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(8'h00, 4'd0, 1'b1);                      // empty message
        send_beat(8'hFF, 4'd8, 1'b0);
        send_beat(8'h00, 4'd8, 1'b1);                      // end with full byte
        send_beat(8'hFF, 4'd8, 1'b0);
        send_beat(8'hAA, 4'd1, 1'b1);                      // end with one bit
        send_beat(8'h55, 4'd7, 1'b1);                      // end with seven bits
        send_beat(8'h12, 4'd15, 1'b1);                     // valid bits above eight
        send_beat(8'h34, 4'd3, 1'b0);                      // partial before end
        send_beat(8'h56, 4'd8, 1'b0);                      // ignored under error
        send_beat(8'h78, 4'd0, 1'b1);
        send_beat(8'h9A, 4'd0, 1'b0);                      // no-data beat
        send_beat(8'hBC, 4'd5, 1'b0);
        send_beat(8'hDE, 4'd6, 1'b1);                      // error kept at end
        wait_drained();
    endtask

    task automatic test_block_edges();
        // Marker lands late in the block, length spills into a second block
        for (int i = 0; i < 59; i++) send_beat(8'($urandom), 4'd8, 1'b0);
        send_beat(8'h00, 4'd0, 1'b1);
        // End beat carries the byte that completes a block
        for (int i = 0; i < 63; i++) send_beat(8'($urandom), 4'd8, 1'b0);
        send_beat(8'($urandom), 4'd8, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        for (int m = 0; m < 4; m++) begin
            if ($urandom_range(9) == 0) send_beat(8'($urandom), 4'($urandom_range(7, 1)), 1'b0);
            send_message($urandom_range(3));
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        rx_idle_free = 1'b1;
        for (int m = 0; m < 2; m++) send_message($urandom_range(4), 0);
        wait_drained();
        rx_idle_free = 1'b0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (1500) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int m = 0; m < 4; m++) send_message($urandom_range(2), 0);
        join
        wait_drained();
    endtask

    initial begin
        rx_idle_free     = 1'b0;
        rx_hold          = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_byte_value     = '0;
        i_valid_bits     = '0;
        i_end_of_message = 1'b0;
        restart_message();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_block_edges();
        test_random();
        test_no_idle();
        test_backpressure();
        if (fail_count == 0 && expected_digests.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
